FILE: rtl/tevq_pkg.sv
package tevq_pkg;

  localparam int QUEUE_DEPTH = 16;
  localparam int IDX_W       = $clog2(QUEUE_DEPTH);
  localparam int MAX_FIRES   = 64;
  localparam int FIRE_W      = $clog2(MAX_FIRES + 1);
  localparam int TIME_W      = 63;
  localparam int ID_W        = 8;
  localparam int PER_W       = 48;
  localparam int ORD_W       = 64;

  typedef enum logic [1:0] {
    CMD_SCHED   = 2'd0,
    CMD_REMOVE  = 2'd1,
    CMD_ADVANCE = 2'd2,
    CMD_CLEAR   = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    KIND_ACK     = 2'd0,
    KIND_FIRE    = 2'd1,
    KIND_SUMMARY = 2'd2
  } kind_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCHED,
    ST_CLR,
    ST_SCAN,
    ST_DECIDE,
    ST_FIRE,
    ST_EMIT
  } state_t;

  // controller to datapath
  typedef struct packed {
    logic  load;
    logic  sched_wr;
    logic  clr_wr;
    logic  scan_start;
    logic  scan_step;
    logic  fire;
    logic  out_load;
    kind_t out_kind;
  } ctrl_cmd_t;

  // datapath to controller
  typedef struct packed {
    cmd_t cmd;
    logic scan_last;
    logic found;
    logic due_ok;
    logic out_last;
  } dp_stat_t;

endpackage

FILE: rtl/timed_event_queue_core.sv
// Timed event queue: entries ordered by due time, then insertion order.
// Input channel in_*: one command per transfer (schedule, remove by id,
// advance, clear). Result channel out_*: schedule, remove and clear give one
// acknowledge; advance gives one fired result per due entry, then a summary,
// or stops after 64 fires with last set on the final fired result.
// Every result carries the earliest remaining due time or queue_empty.
// cfg_wr_en/cfg_wr_data write pause_end; write only when idle.
// Timing: a command is taken only when the block is idle. Every result but
// a summary after a fire waits for a full scan of the 16 slots, one slot
// per cycle. The first fire of an advance follows a scan to find it and a
// scan after the requeue; each further fire follows one scan after its
// requeue, and the summary after the last fire needs no new scan.
// Results sit in an output register; while the receiver stalls the block
// holds the result and takes no new command.
// Reset (rst_n low, synchronous) empties the queue, zeroes the order
// counter and pause_end; no clearing pass is needed.
module timed_event_queue_core (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        cfg_wr_en,
  input  logic [tevq_pkg::TIME_W-1:0] cfg_wr_data,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic [1:0]                  in_cmd,
  input  logic [tevq_pkg::ID_W-1:0]   in_event_id,
  input  logic [tevq_pkg::TIME_W-1:0] in_time_value,
  input  logic                        in_is_absolute,
  input  logic [tevq_pkg::PER_W-1:0]  in_period,
  input  logic [tevq_pkg::TIME_W-1:0] in_now,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [1:0]                  out_kind,
  output logic [tevq_pkg::ID_W-1:0]   out_fired_id,
  output logic [tevq_pkg::TIME_W-1:0] out_due_time,
  output logic [tevq_pkg::TIME_W-1:0] out_lateness,
  output logic [tevq_pkg::TIME_W-1:0] out_next_due,
  output logic                        out_queue_empty,
  output logic                        out_status,
  output logic                        out_last
);
  import tevq_pkg::*;

  ctrl_cmd_t ctl;
  dp_stat_t  stat;

  tevq_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .stat      (stat),
    .ctl       (ctl)
  );

  tevq_dp u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_wr_en       (cfg_wr_en),
    .cfg_wr_data     (cfg_wr_data),
    .in_cmd          (in_cmd),
    .in_event_id     (in_event_id),
    .in_time_value   (in_time_value),
    .in_is_absolute  (in_is_absolute),
    .in_period       (in_period),
    .in_now          (in_now),
    .ctl             (ctl),
    .stat            (stat),
    .out_kind        (out_kind),
    .out_fired_id    (out_fired_id),
    .out_due_time    (out_due_time),
    .out_lateness    (out_lateness),
    .out_next_due    (out_next_due),
    .out_queue_empty (out_queue_empty),
    .out_status      (out_status),
    .out_last        (out_last)
  );

endmodule

FILE: rtl/tevq_ctrl.sv
module tevq_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  output logic               out_valid,
  input  logic               out_ready,
  input  tevq_pkg::dp_stat_t stat,
  output tevq_pkg::ctrl_cmd_t ctl
);
  import tevq_pkg::*;

  state_t state_r, state_nxt;
  logic   pend_r, pend_nxt;

  // state and pending-fire flag
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      pend_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      pend_r  <= pend_nxt;
    end
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    pend_nxt  = pend_r;
    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          case (cmd_t'(stat.cmd))
            CMD_SCHED:   state_nxt = ST_SCHED;
            CMD_ADVANCE: state_nxt = ST_SCAN;
            default:     state_nxt = ST_CLR;
          endcase
        end
      end
      ST_SCHED: state_nxt = ST_SCAN;
      ST_CLR:   state_nxt = ST_SCAN;
      ST_SCAN: begin
        if (stat.scan_last) state_nxt = ST_DECIDE;
      end
      ST_DECIDE: begin
        if (pend_r) begin
          pend_nxt  = 1'b0;
          state_nxt = ST_EMIT;
        end else if (stat.cmd == CMD_ADVANCE && stat.found && stat.due_ok) begin
          state_nxt = ST_FIRE;
        end else begin
          state_nxt = ST_EMIT;
        end
      end
      ST_FIRE: begin
        pend_nxt  = 1'b1;
        state_nxt = ST_SCAN;
      end
      ST_EMIT: begin
        if (out_ready) state_nxt = stat.out_last ? ST_IDLE : ST_DECIDE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    ctl       = '0;
    in_ready  = 1'b0;
    out_valid = 1'b0;
    case (state_r)
      ST_IDLE: begin
        in_ready       = 1'b1;
        ctl.load       = in_valid;
        ctl.scan_start = in_valid;
      end
      ST_SCHED: begin
        ctl.sched_wr   = 1'b1;
        ctl.scan_start = 1'b1;
      end
      ST_CLR: begin
        ctl.clr_wr     = 1'b1;
        ctl.scan_start = 1'b1;
      end
      ST_SCAN: ctl.scan_step = 1'b1;
      ST_DECIDE: begin
        if (pend_r) begin
          ctl.out_load = 1'b1;
          ctl.out_kind = KIND_FIRE;
        end else if (stat.cmd != CMD_ADVANCE) begin
          ctl.out_load = 1'b1;
          ctl.out_kind = KIND_ACK;
        end else if (!(stat.found && stat.due_ok)) begin
          ctl.out_load = 1'b1;
          ctl.out_kind = KIND_SUMMARY;
        end
      end
      ST_FIRE: begin
        ctl.fire       = 1'b1;
        ctl.scan_start = 1'b1;
      end
      ST_EMIT: out_valid = 1'b1;
      default: ;
    endcase
  end

endmodule

FILE: rtl/tevq_dp.sv
module tevq_dp (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        cfg_wr_en,
  input  logic [tevq_pkg::TIME_W-1:0] cfg_wr_data,
  input  logic [1:0]                  in_cmd,
  input  logic [tevq_pkg::ID_W-1:0]   in_event_id,
  input  logic [tevq_pkg::TIME_W-1:0] in_time_value,
  input  logic                        in_is_absolute,
  input  logic [tevq_pkg::PER_W-1:0]  in_period,
  input  logic [tevq_pkg::TIME_W-1:0] in_now,
  input  tevq_pkg::ctrl_cmd_t         ctl,
  output tevq_pkg::dp_stat_t          stat,
  output logic [1:0]                  out_kind,
  output logic [tevq_pkg::ID_W-1:0]   out_fired_id,
  output logic [tevq_pkg::TIME_W-1:0] out_due_time,
  output logic [tevq_pkg::TIME_W-1:0] out_lateness,
  output logic [tevq_pkg::TIME_W-1:0] out_next_due,
  output logic                        out_queue_empty,
  output logic                        out_status,
  output logic                        out_last
);
  import tevq_pkg::*;

  localparam logic [TIME_W-1:0] TMAX = '1;

  // slot storage
  logic [QUEUE_DEPTH-1:0] valid_r;
  logic [TIME_W-1:0]      time_r  [QUEUE_DEPTH];
  logic [ORD_W-1:0]       order_r [QUEUE_DEPTH];
  logic [ID_W-1:0]        id_r    [QUEUE_DEPTH];
  logic [PER_W-1:0]       per_r   [QUEUE_DEPTH];
  logic [ORD_W-1:0]       ctr_r;
  logic [TIME_W-1:0]      pause_r;

  // latched command
  cmd_t              cmd_r;
  logic [ID_W-1:0]   ev_id_r;
  logic [TIME_W-1:0] tv_r;
  logic              abs_r;
  logic [PER_W-1:0]  period_r;
  logic [TIME_W-1:0] now_r;
  logic              full_r;

  // scan state and best candidate
  logic [IDX_W-1:0]  idx_r;
  logic              found_r;
  logic [IDX_W-1:0]  b_idx_r;
  logic [TIME_W-1:0] b_time_r;
  logic [ORD_W-1:0]  b_order_r;
  logic [ID_W-1:0]   b_id_r;
  logic [PER_W-1:0]  b_per_r;

  // fired entry
  logic [FIRE_W-1:0] fires_r;
  logic [ID_W-1:0]   f_id_r;
  logic [TIME_W-1:0] f_due_r;
  logic [TIME_W-1:0] f_late_r;
  logic              f_last_r;

  logic [IDX_W-1:0]  free_idx;
  logic              full;
  logic [ORD_W-1:0]  sum_sched, sum_req;
  logic [TIME_W-1:0] sched_time, req_time, req_base;
  logic              less;

  // first free slot
  always_comb begin
    free_idx = '0;
    for (int i = QUEUE_DEPTH - 1; i >= 0; i--) begin
      if (!valid_r[i]) free_idx = IDX_W'(i);
    end
  end
  assign full = &valid_r;

  // saturating time sums
  assign sum_sched  = {1'b0, now_r} + {1'b0, tv_r};
  assign sched_time = abs_r ? tv_r : (sum_sched[TIME_W] ? TMAX : sum_sched[TIME_W-1:0]);
  assign req_base   = (b_time_r < pause_r) ? pause_r : b_time_r;
  assign sum_req    = {1'b0, req_base} + ORD_W'(b_per_r);
  assign req_time   = sum_req[TIME_W] ? TMAX : sum_req[TIME_W-1:0];

  // candidate ordering
  assign less = (time_r[idx_r] < b_time_r) ||
                (time_r[idx_r] == b_time_r && order_r[idx_r] < b_order_r);

  // config register
  always_ff @(posedge clk) begin
    if (!rst_n) pause_r <= '0;
    else if (cfg_wr_en) pause_r <= cfg_wr_data;
  end

  // valid bits and order counter
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
      ctr_r   <= '0;
    end else begin
      if (ctl.sched_wr && !full) begin
        valid_r[free_idx] <= 1'b1;
        ctr_r             <= ctr_r + 1'b1;
      end
      if (ctl.clr_wr) begin
        for (int i = 0; i < QUEUE_DEPTH; i++) begin
          if (cmd_r == CMD_CLEAR || id_r[i] == ev_id_r) valid_r[i] <= 1'b0;
        end
      end
      if (ctl.fire) begin
        if (b_per_r == '0) valid_r[b_idx_r] <= 1'b0;
        else               ctr_r            <= ctr_r + 1'b1;
      end
    end
  end

  // slot payload writes
  always_ff @(posedge clk) begin
    if (ctl.sched_wr && !full) begin
      time_r[free_idx]  <= sched_time;
      order_r[free_idx] <= ctr_r;
      id_r[free_idx]    <= ev_id_r;
      per_r[free_idx]   <= period_r;
    end
    if (ctl.fire && b_per_r != '0) begin
      time_r[b_idx_r]  <= req_time;
      order_r[b_idx_r] <= ctr_r;
    end
  end

  // command capture
  always_ff @(posedge clk) begin
    if (ctl.load) begin
      cmd_r    <= cmd_t'(in_cmd);
      ev_id_r  <= in_event_id;
      tv_r     <= in_time_value;
      abs_r    <= in_is_absolute;
      period_r <= in_period;
      now_r    <= in_now;
    end
    if (ctl.load)          full_r <= 1'b0;
    else if (ctl.sched_wr) full_r <= full;
  end

  // earliest-entry scan, one slot per cycle
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r   <= '0;
      found_r <= 1'b0;
    end else if (ctl.scan_start) begin
      idx_r   <= '0;
      found_r <= 1'b0;
    end else if (ctl.scan_step) begin
      idx_r <= idx_r + 1'b1;
      if (valid_r[idx_r] && (!found_r || less)) found_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.scan_step && valid_r[idx_r] && (!found_r || less)) begin
      b_idx_r   <= idx_r;
      b_time_r  <= time_r[idx_r];
      b_order_r <= order_r[idx_r];
      b_id_r    <= id_r[idx_r];
      b_per_r   <= per_r[idx_r];
    end
  end

  // fire bookkeeping
  always_ff @(posedge clk) begin
    if (!rst_n) fires_r <= '0;
    else if (ctl.load) fires_r <= '0;
    else if (ctl.fire) fires_r <= fires_r + 1'b1;
  end

  always_ff @(posedge clk) begin
    if (ctl.fire) begin
      f_id_r   <= b_id_r;
      f_due_r  <= b_time_r;
      f_late_r <= now_r - b_time_r;
      f_last_r <= (fires_r == FIRE_W'(MAX_FIRES - 1));
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (ctl.out_load) begin
      out_kind        <= ctl.out_kind;
      out_next_due    <= found_r ? b_time_r : '0;
      out_queue_empty <= !found_r;
      out_status      <= (ctl.out_kind == KIND_ACK) ? full_r : 1'b0;
      if (ctl.out_kind == KIND_FIRE) begin
        out_fired_id <= f_id_r;
        out_due_time <= f_due_r;
        out_lateness <= f_late_r;
        out_last     <= f_last_r;
      end else begin
        out_fired_id <= '0;
        out_due_time <= '0;
        out_lateness <= '0;
        out_last     <= 1'b1;
      end
    end
  end

  // status to controller
  always_comb begin
    stat.cmd       = ctl.load ? cmd_t'(in_cmd) : cmd_r;
    stat.scan_last = (idx_r == IDX_W'(QUEUE_DEPTH - 1));
    stat.found     = found_r;
    stat.due_ok    = (b_time_r <= now_r);
    stat.out_last  = out_last;
  end

endmodule

FILE: rtl/tevq_checker.sv
module tevq_checker (
  input logic                        clk,
  input logic                        rst_n,
  input logic                        in_ready,
  input logic                        out_valid,
  input logic                        out_ready,
  input logic [1:0]                  out_kind,
  input logic [tevq_pkg::TIME_W-1:0] out_next_due,
  input logic                        out_queue_empty,
  input logic                        out_last
);
  import tevq_pkg::*;

  // a stalled result holds
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_kind) && $stable(out_last))
    else $error("stalled result changed");

  // no new command while a result is pending
  a_excl: assert property (@(posedge clk) disable iff (!rst_n)
    !(in_ready && out_valid))
    else $error("input taken while result pending");

  // summary always ends a command
  a_sum: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_kind == KIND_SUMMARY |-> out_last)
    else $error("summary without last");

  // empty queue reports zero next due
  a_empty: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_queue_empty |-> out_next_due == '0)
    else $error("empty queue with next due");

endmodule

bind timed_event_queue_core tevq_checker u_tevq_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .in_ready        (in_ready),
  .out_valid       (out_valid),
  .out_ready       (out_ready),
  .out_kind        (out_kind),
  .out_next_due    (out_next_due),
  .out_queue_empty (out_queue_empty),
  .out_last        (out_last)
);
